>>> hdl/btpm_pkg.sv
// ----------------------------------------------------------------------------
// btpm_pkg: shared types and constants for the binary trie prefix matcher
// Node store geometry, field widths, action and status codes, node records.
// ----------------------------------------------------------------------------
package btpm_pkg;

  // Node store geometry
  localparam int NODES  = 4096;
  localparam int NODE_W = $clog2(NODES);

  // Field widths
  localparam int KEY_W  = 64;
  localparam int LEN_W  = 7;
  localparam int PRIO_W = 32;
  localparam int CNT_W  = 13;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // Requested operation
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Completion status
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BLOCKED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // One trie node as read from the store
  typedef struct packed {
    logic [NODE_W-1:0] c0;
    logic [NODE_W-1:0] c1;
    logic [PRIO_W-1:0] pr;
  } node_t;

  // Write request into the store, with one enable per field
  typedef struct packed {
    logic              we_c0;
    logic              we_c1;
    logic              we_pr;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] c0;
    logic [NODE_W-1:0] c1;
    logic [PRIO_W-1:0] pr;
  } node_wr_t;

endpackage

>>> hdl/btpm_node_store.sv
// ----------------------------------------------------------------------------
// btpm_node_store: trie node memory with the root held in registers
// Three field memories with one write and one registered read per cycle.
// Address 0 is the root, kept in flops so that reset and clear are instant.
// ----------------------------------------------------------------------------
module btpm_node_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [btpm_pkg::NODE_W-1:0] rd_addr,
  input  btpm_pkg::node_wr_t          wr,
  output btpm_pkg::node_t             node
);

  logic [btpm_pkg::NODE_W-1:0] mem_c0 [btpm_pkg::NODES];
  logic [btpm_pkg::NODE_W-1:0] mem_c1 [btpm_pkg::NODES];
  logic [btpm_pkg::PRIO_W-1:0] mem_pr [btpm_pkg::NODES];

  logic [btpm_pkg::NODE_W-1:0] rd_c0_r;
  logic [btpm_pkg::NODE_W-1:0] rd_c1_r;
  logic [btpm_pkg::PRIO_W-1:0] rd_pr_r;
  logic                        rd_root_r;

  logic [btpm_pkg::NODE_W-1:0] root_c0_r;
  logic [btpm_pkg::NODE_W-1:0] root_c1_r;
  logic [btpm_pkg::PRIO_W-1:0] root_pr_r;

  logic wr_root;

  assign wr_root = (wr.addr == '0);

  // Field memories: write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.we_c0) begin
      mem_c0[wr.addr] <= wr.c0;
    end
    if (rd_en) begin
      rd_c0_r <= mem_c0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_c1) begin
      mem_c1[wr.addr] <= wr.c1;
    end
    if (rd_en) begin
      rd_c1_r <= mem_c1[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_pr) begin
      mem_pr[wr.addr] <= wr.pr;
    end
    if (rd_en) begin
      rd_pr_r <= mem_pr[rd_addr];
    end
  end

  // Remember whether the pending read targets the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_root_r <= 1'b0;
    end else if (rd_en) begin
      rd_root_r <= (rd_addr == '0);
    end
  end

  // Root node registers
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      root_c0_r <= '0;
      root_c1_r <= '0;
      root_pr_r <= '0;
    end else if (wr_root) begin
      if (wr.we_c0) begin
        root_c0_r <= wr.c0;
      end
      if (wr.we_c1) begin
        root_c1_r <= wr.c1;
      end
      if (wr.we_pr) begin
        root_pr_r <= wr.pr;
      end
    end
  end

  // Node view: live root registers or the registered memory word
  always_comb begin
    if (rd_root_r) begin
      node.c0 = root_c0_r;
      node.c1 = root_c1_r;
      node.pr = root_pr_r;
    end else begin
      node.c0 = rd_c0_r;
      node.c1 = rd_c1_r;
      node.pr = rd_pr_r;
    end
  end

endmodule

>>> hdl/binary_trie_prefix_match.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_match: longest prefix match over a binary trie
// Insert, lookup and clear of prefix rules in a 4096 node store.
// ----------------------------------------------------------------------------
// Usage:
//   One transaction in on the in_ channel (action, key, prefix length,
//   priority) gives exactly one transaction out on the out_ channel (match
//   priority, status, rule and node counts after the operation).
//   A sequencer walks the trie one level per cycle: each cycle the node
//   store returns the current node and issues the read of its child.
//   Lookup walks from the root one level per key bit, up to 64 levels below
//   the root, and stops early at an empty child link. Insert walks one level
//   per prefix bit and stops early when blocked or full. Clear and the unused
//   action: result on the next cycle.
//   One transaction is in flight at a time: in_stall is high from
//   acceptance until the result has been taken, so the next item can be
//   accepted in the cycle after the result transaction.
//   While out_stall is high the result holds steady on the out_ ports.
//   Reset (synchronous, rst_n low) empties the trie: the root is held in
//   flops and a node is written when it is allocated, so no clearing pass
//   is needed and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module binary_trie_prefix_match (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [btpm_pkg::ACT_W-1:0]  in_action,
  input  logic [btpm_pkg::KEY_W-1:0]  in_key_bits,
  input  logic [btpm_pkg::LEN_W-1:0]  in_prefix_len,
  input  logic [btpm_pkg::PRIO_W-1:0] in_rule_priority,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [btpm_pkg::PRIO_W-1:0] out_match_priority,
  output logic [btpm_pkg::STAT_W-1:0] out_status,
  output logic [btpm_pkg::CNT_W-1:0]  out_rules_stored,
  output logic [btpm_pkg::CNT_W-1:0]  out_nodes_used
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [btpm_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [btpm_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [btpm_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic [btpm_pkg::LEN_W-1:0]    level_r, level_nxt;
  logic [btpm_pkg::NODE_W-1:0]   cur_r, cur_nxt;
  logic                          fresh_r, fresh_nxt;
  logic [btpm_pkg::PRIO_W-1:0]   match_r, match_nxt;
  logic [btpm_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic [btpm_pkg::ACT_W-1:0]    op_r, op_nxt;
  logic [btpm_pkg::CNT_W-1:0]    next_free_r, next_free_nxt;
  logic [btpm_pkg::CNT_W-1:0]    rule_total_r, rule_total_nxt;

  btpm_pkg::node_t               node;
  btpm_pkg::node_wr_t            wr;
  logic                          rd_en;
  logic [btpm_pkg::NODE_W-1:0]   rd_addr;
  logic                          clear;

  logic                          key_bit;
  logic [btpm_pkg::NODE_W-1:0]   child;
  logic [btpm_pkg::NODE_W-1:0]   alloc_node;
  logic                          store_full;
  logic                          at_len;
  logic                          at_key_end;
  logic [btpm_pkg::LEN_W-1:0]    len_sat;

  btpm_node_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .node    (node)
  );

  // Walk helpers
  assign key_bit    = key_r[btpm_pkg::KEY_W-1];
  assign child      = key_bit ? node.c1 : node.c0;
  assign alloc_node = next_free_r[btpm_pkg::NODE_W-1:0];
  assign store_full = (next_free_r >= btpm_pkg::CNT_W'(btpm_pkg::NODES));
  assign at_len     = (level_r == len_r);
  assign at_key_end = (level_r == btpm_pkg::LEN_W'(btpm_pkg::KEY_W));
  assign len_sat    = (in_prefix_len > btpm_pkg::LEN_W'(btpm_pkg::KEY_W)) ?
                      btpm_pkg::LEN_W'(btpm_pkg::KEY_W) : in_prefix_len;

  // Handshake and result ports
  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_DONE);
  assign out_match_priority = match_r;
  assign out_status         = status_r;
  assign out_rules_stored   = rule_total_r;
  assign out_nodes_used     = next_free_r - btpm_pkg::CNT_W'(1);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    prio_nxt       = prio_r;
    level_nxt      = level_r;
    cur_nxt        = cur_r;
    fresh_nxt      = fresh_r;
    match_nxt      = match_r;
    status_nxt     = status_r;
    op_nxt         = op_r;
    next_free_nxt  = next_free_r;
    rule_total_nxt = rule_total_r;
    wr             = '0;
    wr.addr        = cur_r;
    rd_en          = 1'b0;
    rd_addr        = child;
    clear          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_key_bits;
          len_nxt    = len_sat;
          prio_nxt   = in_rule_priority;
          level_nxt  = '0;
          cur_nxt    = '0;
          fresh_nxt  = 1'b0;
          match_nxt  = '0;
          status_nxt = btpm_pkg::STAT_DONE;
          op_nxt     = in_action;
          case (in_action)
            btpm_pkg::ACT_INSERT: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_INSERT;
            end
            btpm_pkg::ACT_LOOKUP: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_LOOKUP;
            end
            btpm_pkg::ACT_CLEAR: begin
              clear          = 1'b1;
              next_free_nxt  = btpm_pkg::CNT_W'(1);
              rule_total_nxt = '0;
              state_nxt      = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // One level per cycle; deepest nonzero priority wins
      ST_LOOKUP: begin
        if (node.pr != '0) begin
          match_nxt = node.pr;
        end
        if (at_key_end || child == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          cur_nxt   = child;
          level_nxt = level_r + btpm_pkg::LEN_W'(1);
          key_nxt   = key_r << 1;
        end
      end

      ST_INSERT: begin
        if (fresh_r) begin
          // Node just allocated: its whole word is written once, here
          wr.we_c0 = 1'b1;
          wr.we_c1 = 1'b1;
          wr.we_pr = 1'b1;
          if (at_len) begin
            wr.pr = prio_r;
            if (prio_r != '0) begin
              rule_total_nxt = rule_total_r + btpm_pkg::CNT_W'(1);
            end
            state_nxt = ST_DONE;
          end else if (store_full) begin
            status_nxt = btpm_pkg::STAT_FULL;
            state_nxt  = ST_DONE;
          end else begin
            wr.c0         = key_bit ? '0 : alloc_node;
            wr.c1         = key_bit ? alloc_node : '0;
            next_free_nxt = next_free_r + btpm_pkg::CNT_W'(1);
            cur_nxt       = alloc_node;
            level_nxt     = level_r + btpm_pkg::LEN_W'(1);
            key_nxt       = key_r << 1;
          end
        end else if (node.pr != '0 && (cur_r != '0 || len_r == '0)) begin
          // Existing rule on the path (root only for a zero length rule)
          status_nxt = btpm_pkg::STAT_BLOCKED;
          state_nxt  = ST_DONE;
        end else if (at_len) begin
          if (prio_r != '0) begin
            wr.we_pr       = 1'b1;
            wr.pr          = prio_r;
            rule_total_nxt = rule_total_r + btpm_pkg::CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end else if (child != '0) begin
          rd_en     = 1'b1;
          cur_nxt   = child;
          level_nxt = level_r + btpm_pkg::LEN_W'(1);
          key_nxt   = key_r << 1;
        end else if (store_full) begin
          status_nxt = btpm_pkg::STAT_FULL;
          state_nxt  = ST_DONE;
        end else begin
          // Link a new node under the existing one and go fresh
          wr.we_c0      = ~key_bit;
          wr.we_c1      = key_bit;
          wr.c0         = alloc_node;
          wr.c1         = alloc_node;
          next_free_nxt = next_free_r + btpm_pkg::CNT_W'(1);
          cur_nxt       = alloc_node;
          fresh_nxt     = 1'b1;
          level_nxt     = level_r + btpm_pkg::LEN_W'(1);
          key_nxt       = key_r << 1;
        end
      end

      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      level_r      <= '0;
      fresh_r      <= 1'b0;
      next_free_r  <= btpm_pkg::CNT_W'(1);
      rule_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      level_r      <= level_nxt;
      fresh_r      <= fresh_nxt;
      next_free_r  <= next_free_nxt;
      rule_total_r <= rule_total_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    prio_r   <= prio_nxt;
    cur_r    <= cur_nxt;
    match_r  <= match_nxt;
    status_r <= status_nxt;
    op_r     <= op_nxt;
  end

  // Allocation never runs past the store
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= btpm_pkg::CNT_W'(btpm_pkg::NODES))
    else $error("node allocation past end of store");

  // Every stored rule owns a distinct node
  a_rules_le_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    rule_total_r <= next_free_r)
    else $error("more rules than allocated nodes");

  // An insert walk never goes deeper than its prefix
  a_insert_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> (level_r <= len_r))
    else $error("insert walked past prefix length");

  // Non-done status only comes from an insert
  a_status_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != btpm_pkg::STAT_DONE) |-> (op_r == btpm_pkg::ACT_INSERT))
    else $error("error status on a non-insert transaction");

  // A match is reported only for a lookup
  a_match_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_priority != '0) |-> (op_r == btpm_pkg::ACT_LOOKUP))
    else $error("match priority on a non-lookup transaction");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the binary trie prefix matcher
// A driver feeds insert, lookup and clear transactions from a queue and
// keeps a shadow trie that predicts every result. A monitor takes the
// result transactions under random stall and checks them field by field.
// Stimulus opens with a directed set of corner cases, then runs random
// episodes that each start from an empty trie; some of them fill the
// node store to its limit.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [btpm_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_OPS     = 600;
  localparam int MAX_WAIT       = 14;
  localparam int HOLD_AT        = 120;   // result after which the receiver holds off
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 100;

  typedef struct {
    logic [btpm_pkg::ACT_W-1:0]  action;
    logic [btpm_pkg::KEY_W-1:0]  key;
    logic [btpm_pkg::LEN_W-1:0]  len;
    logic [btpm_pkg::PRIO_W-1:0] prio;
    bit                          drain;   // sender waits for all results before offering
  } trie_op_t;

  typedef struct {
    logic [btpm_pkg::PRIO_W-1:0] match;
    logic [btpm_pkg::STAT_W-1:0] status;
    logic [btpm_pkg::CNT_W-1:0]  rules;
    logic [btpm_pkg::CNT_W-1:0]  nodes;
  } trie_result_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [btpm_pkg::ACT_W-1:0]    in_action = '0;
  logic [btpm_pkg::KEY_W-1:0]    in_key_bits = '0;
  logic [btpm_pkg::LEN_W-1:0]    in_prefix_len = '0;
  logic [btpm_pkg::PRIO_W-1:0]   in_rule_priority = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [btpm_pkg::PRIO_W-1:0]   out_match_priority;
  logic [btpm_pkg::STAT_W-1:0]   out_status;
  logic [btpm_pkg::CNT_W-1:0]    out_rules_stored;
  logic [btpm_pkg::CNT_W-1:0]    out_nodes_used;

  trie_op_t     op_queue[$];
  trie_result_t expected_results[$];
  trie_op_t     offered_op;
  int           gap_left = 0;
  int           stall_left = 0;
  int           ops_accepted = 0;
  int           results_taken = 0;
  int           quiet_cycles = 0;
  int           fails = 0;

  // Shadow trie
  logic [btpm_pkg::NODE_W-1:0] trie_c0 [btpm_pkg::NODES];
  logic [btpm_pkg::NODE_W-1:0] trie_c1 [btpm_pkg::NODES];
  logic [btpm_pkg::PRIO_W-1:0] trie_pr [btpm_pkg::NODES];
  int unsigned                 free_idx;
  int unsigned                 rule_cnt;

  binary_trie_prefix_match uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_key_bits        (in_key_bits),
    .in_prefix_len      (in_prefix_len),
    .in_rule_priority   (in_rule_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_priority (out_match_priority),
    .out_status         (out_status),
    .out_rules_stored   (out_rules_stored),
    .out_nodes_used     (out_nodes_used)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow trie
  function automatic void trie_clear();
    trie_c0[0] = '0;
    trie_c1[0] = '0;
    trie_pr[0] = '0;
    free_idx   = 1;
    rule_cnt   = 0;
  endfunction

  function automatic logic [btpm_pkg::STAT_W-1:0] trie_insert(
      input logic [btpm_pkg::KEY_W-1:0]  key,
      input logic [btpm_pkg::LEN_W-1:0]  len_in,
      input logic [btpm_pkg::PRIO_W-1:0] prio);
    int unsigned len;
    int unsigned lvl;
    int unsigned cur;
    int unsigned nxt;
    logic        b;
    // saturate at key width
    len = (len_in > btpm_pkg::KEY_W) ? btpm_pkg::KEY_W : 32'(len_in);
    if (len == 0 && trie_pr[0] != 0) return btpm_pkg::STAT_BLOCKED;
    cur = 0;
    for (lvl = 0; lvl < len; lvl++) begin
      b   = key[btpm_pkg::KEY_W-1-lvl];
      nxt = b ? 32'(trie_c1[cur]) : 32'(trie_c0[cur]);
      if (nxt == 0) begin
        if (free_idx >= btpm_pkg::NODES) return btpm_pkg::STAT_FULL;
        nxt = free_idx;
        free_idx++;
        trie_c0[nxt] = '0;
        trie_c1[nxt] = '0;
        trie_pr[nxt] = '0;
        if (b) trie_c1[cur] = nxt[btpm_pkg::NODE_W-1:0];
        else trie_c0[cur] = nxt[btpm_pkg::NODE_W-1:0];
      end
      cur = nxt;
      if (trie_pr[cur] != 0) return btpm_pkg::STAT_BLOCKED;
    end
    // zero priority walks and allocates but stores nothing
    if (prio != 0) begin
      trie_pr[cur] = prio;
      rule_cnt++;
    end
    return btpm_pkg::STAT_DONE;
  endfunction

  function automatic logic [btpm_pkg::PRIO_W-1:0] trie_lookup(
      input logic [btpm_pkg::KEY_W-1:0] key);
    int unsigned                 lvl;
    int unsigned                 cur;
    logic [btpm_pkg::PRIO_W-1:0] best;
    cur  = 0;
    best = trie_pr[0];
    for (lvl = 0; lvl < btpm_pkg::KEY_W; lvl++) begin
      cur = key[btpm_pkg::KEY_W-1-lvl] ? 32'(trie_c1[cur]) : 32'(trie_c0[cur]);
      if (cur == 0) break;
      if (trie_pr[cur] != 0) best = trie_pr[cur];
    end
    return best;
  endfunction

  task automatic trie_apply(input trie_op_t op);
    trie_result_t r;
    r.match  = '0;
    r.status = btpm_pkg::STAT_DONE;
    case (op.action)
      btpm_pkg::ACT_INSERT: r.status = trie_insert(op.key, op.len, op.prio);
      btpm_pkg::ACT_LOOKUP: r.match = trie_lookup(op.key);
      btpm_pkg::ACT_CLEAR:  trie_clear();
      default:              ;
    endcase
    r.rules = rule_cnt[btpm_pkg::CNT_W-1:0];
    r.nodes = btpm_pkg::CNT_W'(free_idx - 1);
    expected_results.insert(expected_results.size(), r);
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [btpm_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [btpm_pkg::LEN_W-1:0] rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 50) return btpm_pkg::LEN_W'($urandom_range(1, 16));
    if (roll < 85) return btpm_pkg::LEN_W'($urandom_range(17, 64));
    return btpm_pkg::LEN_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [btpm_pkg::PRIO_W-1:0] rand_prio();
    int          roll;
    logic [31:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 10) return '1;
    p = $urandom;
    return (p == 0) ? 32'd1 : p;
  endfunction

  // Idle cycles per transaction; every third stretch of 40 runs back to back
  function automatic int pick_wait(input int count);
    if ((count / 40) % 3 == 1) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic queue_op(input logic [btpm_pkg::ACT_W-1:0] act,
                          input logic [btpm_pkg::KEY_W-1:0] key,
                          input logic [btpm_pkg::LEN_W-1:0] len,
                          input logic [btpm_pkg::PRIO_W-1:0] prio,
                          input bit drain);
    trie_op_t op;
    op.action = act;
    op.key    = key;
    op.len    = len;
    op.prio   = prio;
    op.drain  = drain;
    op_queue.insert(op_queue.size(), op);
  endtask

  task automatic offer(input trie_op_t op);
    offered_op       = op;
    in_valid         <= 1'b1;
    in_action        <= op.action;
    in_key_bits      <= op.key;
    in_prefix_len    <= op.len;
    in_rule_priority <= op.prio;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : driver
    int gap_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      trie_apply(offered_op);
      ops_accepted++;
      gap_next = pick_wait(ops_accepted);
      if (gap_next == 0 && op_queue.size() > 0 && !op_queue[0].drain) begin
        offer(op_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
        gap_left <= gap_next;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (op_queue.size() > 0 &&
                   (!op_queue[0].drain || (expected_results.size() == 0 && !out_valid))) begin
        offer(op_queue.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    trie_result_t want;
    int           hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          $error("result transaction with none expected: status %0d", out_status);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_match_priority !== want.match) begin
            $error("match_priority: expected %0h, got %0h", want.match, out_match_priority);
            fails++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_rules_stored !== want.rules) begin
            $error("rules_stored: expected %0d, got %0d", want.rules, out_rules_stored);
            fails++;
          end
          if (out_nodes_used !== want.nodes) begin
            $error("nodes_used: expected %0d, got %0d", want.nodes, out_nodes_used);
            fails++;
          end
        end
        // one long hold-off lets the block back up onto its input
        hold = (results_taken == HOLD_AT) ? LONG_HOLD : pick_wait(results_taken);
      end
      if (hold > 0) begin
        out_stall  <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run
    logic [btpm_pkg::KEY_W-1:0]  ones;
    logic [btpm_pkg::KEY_W-1:0]  pat;
    logic [btpm_pkg::KEY_W-1:0]  base;
    logic [btpm_pkg::KEY_W-1:0]  key;
    logic [btpm_pkg::KEY_W-1:0]  keys[$];
    logic [btpm_pkg::ACT_W-1:0]  act;
    logic [btpm_pkg::LEN_W-1:0]  len;
    int                          n_rand;
    int                          ep;
    int                          ep_len;
    int                          roll;
    int                          i;
    bit                          fill_run;

    trie_clear();
    ones = '1;
    pat  = 64'hA5A5_A5A5_A5A5_A5A5;

    // Directed corner cases
    queue_op(btpm_pkg::ACT_LOOKUP, '0, '0, '0, 1'b0);           // miss on empty trie
    queue_op(btpm_pkg::ACT_INSERT, rand_key(), '0, 32'd5, 1'b0); // zero length rule in root
    queue_op(btpm_pkg::ACT_INSERT, rand_key(), '0, 32'd6, 1'b0); // root already holds a rule
    queue_op(btpm_pkg::ACT_LOOKUP, ones, 7'd0, '0, 1'b0);        // root rule matches anything
    queue_op(btpm_pkg::ACT_INSERT, ones, 7'd64, '1, 1'b0);       // full depth, max priority
    queue_op(btpm_pkg::ACT_INSERT, ones, 7'd127, 32'd7, 1'b0);   // saturated length, blocked
    queue_op(btpm_pkg::ACT_INSERT, '0, 7'd1, 32'd9, 1'b0);
    queue_op(btpm_pkg::ACT_INSERT, '0, 7'd64, 32'd10, 1'b0);     // covered by shorter rule
    queue_op(btpm_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 7'd64, '0, 1'b0);  // zero priority
    queue_op(btpm_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_LOOKUP, '0, '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_LOOKUP, ones, '0, '0, 1'b0);
    queue_op(ACT_UNUSED, rand_key(), 7'h7F, '1, 1'b0);           // unused action
    queue_op(btpm_pkg::ACT_CLEAR, ones, 7'h7F, '1, 1'b0);
    queue_op(btpm_pkg::ACT_LOOKUP, ones, '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_INSERT, pat, 7'd65, 32'd1, 1'b0);     // just past key width
    queue_op(btpm_pkg::ACT_INSERT, pat, 7'd8, 32'd2, 1'b0);      // shorter after longer
    queue_op(btpm_pkg::ACT_LOOKUP, pat, '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_LOOKUP, {pat[63:56], 56'd0}, '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_INSERT, '0, 7'h7F, 32'd3, 1'b0);
    queue_op(btpm_pkg::ACT_LOOKUP, rand_key(), '0, '0, 1'b0);
    queue_op(btpm_pkg::ACT_CLEAR, '0, '0, '0, 1'b0);

    // Random episodes, each from an empty trie; every fourth one fills the store
    n_rand = 0;
    ep     = 0;
    while (n_rand < RANDOM_OPS) begin
      fill_run = (ep % 4 == 1);
      ep_len   = fill_run ? 120 : $urandom_range(15, 50);
      queue_op(btpm_pkg::ACT_CLEAR, rand_key(), btpm_pkg::LEN_W'($urandom_range(0, 127)),
               $urandom, 1'b1);
      n_rand++;
      keys.delete();
      for (i = 0; i < 4; i++) keys.insert(keys.size(), rand_key());
      for (i = 0; i < ep_len; i++) begin
        roll = $urandom_range(0, 99);
        base = keys[$urandom_range(0, keys.size() - 1)];
        len  = btpm_pkg::LEN_W'($urandom_range(0, 127));
        if (fill_run && roll < 80) begin
          act = btpm_pkg::ACT_INSERT;
          key = rand_key();
          len = (roll < 65) ? 7'd64 : btpm_pkg::LEN_W'($urandom_range(40, 127));
          keys.insert(keys.size(), key);
        end else if (roll < 45) begin
          act = btpm_pkg::ACT_INSERT;
          key = base ^ (rand_key() >> $urandom_range(1, 64));
          len = rand_len();
          keys.insert(keys.size(), key);
        end else if (roll < 92) begin
          act = btpm_pkg::ACT_LOOKUP;
          key = ($urandom_range(0, 4) == 0) ? rand_key()
                                            : base ^ (rand_key() >> $urandom_range(8, 64));
        end else if (roll < 96) begin
          act = ACT_UNUSED;
          key = rand_key();
        end else begin
          act = btpm_pkg::ACT_CLEAR;
          key = rand_key();
        end
        queue_op(act, key, len, rand_prio(), 1'b0);
        n_rand++;
      end
      ep++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> binary_trie_prefix_match.f
hdl/btpm_pkg.sv
hdl/btpm_node_store.sv
hdl/binary_trie_prefix_match.sv
bench/tb_top.sv
